[sv/fsm_pkg.sv]
`default_nettype none
package fsm_pkg;

    localparam int NUM_BLOCKS      = 64;
    localparam int PAGES_PER_BLOCK = 256;
    localparam int GRAINS_PER_PAGE = 4;

    localparam int TOTAL_PAGES = NUM_BLOCKS * PAGES_PER_BLOCK;
    localparam int MAX_COUNT   = PAGES_PER_BLOCK * GRAINS_PER_PAGE;
    localparam int MAP_END     = NUM_BLOCKS / 20;

    localparam int BLK_W   = $clog2(NUM_BLOCKS);
    localparam int PAGE_W  = $clog2(TOTAL_PAGES);
    localparam int GOFF_W  = $clog2(GRAINS_PER_PAGE);
    localparam int POFF_W  = $clog2(PAGES_PER_BLOCK);
    localparam int CNT_W   = $clog2(MAX_COUNT + 1);
    localparam int WP_W    = $clog2(PAGES_PER_BLOCK + 1);
    localparam int FREE_W  = BLK_W + 1;
    localparam int NUMB_W  = BLK_W + 1;

    localparam logic [BLK_W-1:0]  MAP_LO   = '0;
    localparam logic [BLK_W-1:0]  MAP_HI   = BLK_W'(MAP_END);
    localparam logic [BLK_W-1:0]  DATA_LO  = BLK_W'(MAP_END + 1);
    localparam logic [BLK_W-1:0]  DATA_HI  = BLK_W'(NUM_BLOCKS - 1);
    localparam logic [NUMB_W-1:0] MAP_N    = NUMB_W'(MAP_END + 1);
    localparam logic [NUMB_W-1:0] DATA_N   = NUMB_W'(NUM_BLOCKS - MAP_END - 1);
    localparam logic [FREE_W-1:0] MAP_FREE  = FREE_W'(MAP_END + 1);
    localparam logic [FREE_W-1:0] DATA_FREE = FREE_W'(NUM_BLOCKS - MAP_END - 1);
    localparam logic [GRAINS_PER_PAGE-1:0] PAGE_ALL = '1;

    typedef enum logic [3:0] {
        A_QGRAIN   = 4'd0,
        A_VALGRAIN = 4'd1,
        A_INVGRAIN = 4'd2,
        A_QPAGE    = 4'd3,
        A_VALPAGE  = 4'd4,
        A_INVPAGE  = 4'd5,
        A_ALLOC    = 4'd6,
        A_FULL     = 4'd7,
        A_ACTIVE   = 4'd8,
        A_GCNEED   = 4'd9,
        A_VICTIM   = 4'd10,
        A_TRIM     = 4'd11,
        A_SETRSV   = 4'd12
    } t_action;

    typedef enum logic [3:0] {
        E_OK        = 4'd0,
        E_VALID     = 4'd1,
        E_INVALID   = 4'd2,
        E_DISAGREE  = 4'd3,
        E_OVERFLOW  = 4'd4,
        E_FULL      = 4'd5,
        E_NO_FREE   = 4'd6,
        E_NO_VICTIM = 4'd7,
        E_RSV_BUSY  = 4'd8
    } t_err;

    typedef struct packed {
        logic [3:0]  action;
        logic [15:0] grain_address;
        logic [13:0] page_address;
        logic [5:0]  block_index;
        logic        partition;
        logic        want_reserve;
    } t_req;

    typedef struct packed {
        logic        flag;
        logic [13:0] page_out;
        logic [5:0]  block_out;
        logic        found;
        logic [3:0]  error_code;
    } t_rsp;

endpackage
`default_nettype wire

[sv/fsm_if.sv]
`default_nettype none
interface fsm_req_if import fsm_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fsm_rsp_if import fsm_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[sv/flash_superblock_manager.sv]
// bitmap, counter and partition actions pass through read, execute and deliver states
// active requests without want_reserve and victim requests scan the partition's block
//   table one entry a cycle
// a new request is taken only in the idle state, after the last result has moved to the
//   output register; a result waiting there does not block the next request from being taken
// reset: synchronous active low; the grain bitmap is cleared by a sweep over all 16384 pages
//   after reset during which no request is taken; block table and partition state clear at once
`default_nettype none
module flash_superblock_manager import fsm_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    fsm_req_if.sink     i_req,
    fsm_rsp_if.source   o_rsp
);

    // one-hot sequencer
    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_READ  = 6'b000100,
        S_EXEC  = 6'b001000,
        S_SCAN  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    // scan flavours
    typedef enum logic [2:0] {
        P_FIRST  = 3'b001,
        P_NEXT   = 3'b010,
        P_VICTIM = 3'b100
    } t_phase;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;

    // grain bitmap memory, one mask per page
    logic [GRAINS_PER_PAGE-1:0] r_map_mem [TOTAL_PAGES];
    logic [GRAINS_PER_PAGE-1:0] r_map_q;
    logic [PAGE_W-1:0]          map_ra, map_wa;
    logic [GRAINS_PER_PAGE-1:0] map_wd;
    logic                       map_we;

    // block table memory: valid count and write pointer; per-entry valid bits give zero reset
    logic [CNT_W+WP_W-1:0] r_blk_mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] r_blk_vld;
    logic [CNT_W+WP_W-1:0] r_blk_q;
    logic                  r_blkv_q;
    logic [BLK_W-1:0]      blk_ra, blk_wa;
    logic [CNT_W+WP_W-1:0] blk_wd;
    logic                  blk_we;

    // clearing sweep
    logic [PAGE_W-1:0] r_clr, n_clr;

    // latched request and its decoded addresses
    t_req             r_req;
    logic [PAGE_W-1:0] r_maddr;
    logic [BLK_W-1:0]  r_baddr;

    // partition state
    logic [BLK_W-1:0]  r_active [2];
    logic [1:0]        r_act_vld;
    logic [BLK_W-1:0]  r_rsv [2];
    logic [FREE_W-1:0] r_free [2];
    logic [BLK_W-1:0]  n_active [2];
    logic [1:0]        n_act_vld;
    logic [BLK_W-1:0]  n_rsv [2];
    logic [FREE_W-1:0] n_free [2];

    // scan engine
    logic [BLK_W-1:0]  r_sc_addr, n_sc_addr;
    logic [NUMB_W-1:0] r_sc_left, n_sc_left;
    logic              r_ck_vld, n_ck_vld;
    logic [BLK_W-1:0]  r_ck_idx, n_ck_idx;
    logic              r_got, n_got;
    logic [BLK_W-1:0]  r_best, n_best;
    logic [CNT_W-1:0]  r_min, n_min;
    logic [WP_W-1:0]   r_bwp, n_bwp;

    // result and output register
    t_rsp r_res, n_res;
    t_rsp r_out;
    logic r_out_vld;

    logic req_acc;
    logic out_free;

    // request decode at acceptance
    t_req              in_d;
    logic [PAGE_W-1:0] in_maddr;
    logic [BLK_W-1:0]  in_baddr;

    // execute-time view of the latched request
    logic              p;
    logic [BLK_W-1:0]  lo, hi;
    logic [NUMB_W-1:0] nblk;
    logic [GRAINS_PER_PAGE-1:0] gbit;
    logic [CNT_W-1:0]  cnt, ck_cnt;
    logic [WP_W-1:0]   wp, ck_wp;
    logic [CNT_W:0]    cnt_inc;
    logic              usable, cand, better;
    logic              f_got;
    logic [CNT_W-1:0]  f_min;
    logic [WP_W-1:0]   f_wp;
    logic [BLK_W-1:0]  f_best;

    function automatic logic [BLK_W-1:0] f_nxt(input logic [BLK_W-1:0] a,
                                               input logic [BLK_W-1:0] l,
                                               input logic [BLK_W-1:0] h);
        f_nxt = (a == h) ? l : BLK_W'(a + 1'b1);
    endfunction

    assign req_acc     = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign out_free    = !r_out_vld || o_rsp.ready;
    assign o_rsp.valid = r_out_vld;
    assign o_rsp.data  = r_out;

    // address decode: grain actions go through the page holding the grain
    always_comb begin
        in_d     = i_req.data;
        in_maddr = in_d.page_address;
        in_baddr = in_d.block_index;
        case (in_d.action)
            A_QGRAIN, A_VALGRAIN, A_INVGRAIN: begin
                in_maddr = in_d.grain_address[GOFF_W +: PAGE_W];
                in_baddr = in_d.grain_address[GOFF_W+POFF_W +: BLK_W];
            end
            A_QPAGE, A_VALPAGE, A_INVPAGE: begin
                in_maddr = in_d.page_address;
                in_baddr = in_d.page_address[POFF_W +: BLK_W];
            end
            A_ACTIVE: begin
                in_baddr = r_rsv[in_d.partition];
            end
            default: begin
                in_baddr = in_d.block_index;
            end
        endcase
    end

    // once taken, reads follow the latched addresses or the scan address, not the input bus
    assign map_ra = (r_state == S_IDLE) ? in_maddr : r_maddr;
    assign blk_ra = (r_state == S_SCAN) ? r_sc_addr
                  : (r_state == S_EXEC) ? n_sc_addr
                  : (r_state == S_IDLE) ? in_baddr : r_baddr;

    // memories
    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_map_mem[map_wa] <= map_wd;
        end
        r_map_q <= r_map_mem[map_ra];
    end

    always_ff @(posedge i_clk) begin
        if (blk_we) begin
            r_blk_mem[blk_wa] <= blk_wd;
        end
        r_blk_q <= r_blk_mem[blk_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk_vld <= '0;
            r_blkv_q  <= 1'b0;
        end else begin
            if (blk_we) begin
                r_blk_vld[blk_wa] <= 1'b1;
            end
            r_blkv_q <= r_blk_vld[blk_ra];
        end
    end

    // main sequencer
    always_comb begin
        p      = r_req.partition;
        lo     = p ? DATA_LO : MAP_LO;
        hi     = p ? DATA_HI : MAP_HI;
        nblk   = p ? DATA_N : MAP_N;
        gbit   = GRAINS_PER_PAGE'(1) << r_req.grain_address[GOFF_W-1:0];
        cnt    = r_blkv_q ? r_blk_q[WP_W +: CNT_W] : '0;
        wp     = r_blkv_q ? r_blk_q[WP_W-1:0] : '0;
        ck_cnt = cnt;
        ck_wp  = wp;
        cnt_inc = {1'b0, cnt};

        usable = r_ck_vld && (r_ck_idx != r_rsv[p]) && (ck_wp < WP_W'(PAGES_PER_BLOCK));
        cand   = r_ck_vld && (r_ck_idx != r_rsv[p]) && (ck_wp >= WP_W'(PAGES_PER_BLOCK));
        better = cand && (!r_got || ck_cnt < r_min);
        f_got  = r_got || better;
        f_min  = better ? ck_cnt : r_min;
        f_wp   = better ? ck_wp : r_bwp;
        f_best = better ? r_ck_idx : r_best;

        n_state   = r_state;
        n_phase   = r_phase;
        n_clr     = r_clr;
        n_active  = r_active;
        n_act_vld = r_act_vld;
        n_rsv     = r_rsv;
        n_free    = r_free;
        n_sc_addr = r_sc_addr;
        n_sc_left = r_sc_left;
        n_ck_vld  = 1'b0;
        n_ck_idx  = r_ck_idx;
        n_got     = r_got;
        n_best    = r_best;
        n_min     = r_min;
        n_bwp     = r_bwp;
        n_res     = r_res;

        map_we = 1'b0;
        map_wa = r_maddr;
        map_wd = '0;
        blk_we = 1'b0;
        blk_wa = r_baddr;
        blk_wd = '0;

        case (r_state)
            S_CLEAR: begin
                map_we = 1'b1;
                map_wa = r_clr;
                n_clr  = PAGE_W'(r_clr + 1'b1);
                if (r_clr == PAGE_W'(TOTAL_PAGES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (req_acc) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_res   = '0;
                n_state = S_DONE;
                case (r_req.action)
                    A_QGRAIN: begin
                        n_res.flag = |(r_map_q & gbit);
                    end
                    A_VALGRAIN: begin
                        if (|(r_map_q & gbit)) begin
                            n_res.error_code = E_VALID;
                        end else if (cnt_inc + 1'b1 > (CNT_W+1)'(MAX_COUNT)) begin
                            n_res.error_code = E_OVERFLOW;
                        end else begin
                            map_we = 1'b1;
                            map_wd = r_map_q | gbit;
                            blk_we = 1'b1;
                            blk_wd = {CNT_W'(cnt + 1'b1), wp};
                        end
                    end
                    A_INVGRAIN: begin
                        if (!(|(r_map_q & gbit))) begin
                            n_res.error_code = E_INVALID;
                        end else begin
                            map_we = 1'b1;
                            map_wd = r_map_q & ~gbit;
                            blk_we = 1'b1;
                            blk_wd = {(cnt != '0) ? CNT_W'(cnt - 1'b1) : CNT_W'(0), wp};
                        end
                    end
                    A_QPAGE: begin
                        n_res.flag = r_map_q[0];
                        if (r_map_q != '0 && r_map_q != PAGE_ALL) begin
                            n_res.error_code = E_DISAGREE;
                        end
                    end
                    A_VALPAGE: begin
                        if (r_map_q != '0) begin
                            n_res.error_code = E_VALID;
                        end else if (cnt_inc + (CNT_W+1)'(GRAINS_PER_PAGE)
                                     > (CNT_W+1)'(MAX_COUNT)) begin
                            n_res.error_code = E_OVERFLOW;
                        end else begin
                            map_we = 1'b1;
                            map_wd = PAGE_ALL;
                            blk_we = 1'b1;
                            blk_wd = {CNT_W'(cnt + CNT_W'(GRAINS_PER_PAGE)), wp};
                        end
                    end
                    A_INVPAGE: begin
                        if (r_map_q != PAGE_ALL) begin
                            n_res.error_code = E_INVALID;
                        end else begin
                            map_we = 1'b1;
                            map_wd = '0;
                            blk_we = 1'b1;
                            blk_wd = {(cnt >= CNT_W'(GRAINS_PER_PAGE))
                                      ? CNT_W'(cnt - CNT_W'(GRAINS_PER_PAGE)) : CNT_W'(0), wp};
                        end
                    end
                    A_ALLOC: begin
                        if (wp >= WP_W'(PAGES_PER_BLOCK)) begin
                            n_res.error_code = E_FULL;
                        end else begin
                            n_res.page_out = {r_baddr, wp[POFF_W-1:0]};
                            blk_we = 1'b1;
                            blk_wd = {cnt, WP_W'(wp + 1'b1)};
                        end
                    end
                    A_FULL: begin
                        n_res.flag = (wp >= WP_W'(PAGES_PER_BLOCK));
                    end
                    A_ACTIVE: begin
                        if (r_req.want_reserve) begin
                            n_res.block_out = r_rsv[p];
                            n_res.found     = 1'b1;
                            if (wp != '0 || cnt != '0) begin
                                n_res.error_code = E_RSV_BUSY;
                            end
                        end else begin
                            // walk from the current active block, or find one first
                            n_state = S_SCAN;
                            if (r_act_vld[p]) begin
                                n_phase   = P_NEXT;
                                n_sc_addr = f_nxt(r_active[p], lo, hi);
                                n_sc_left = NUMB_W'(nblk - 1'b1);
                            end else begin
                                n_phase   = P_FIRST;
                                n_sc_addr = lo;
                                n_sc_left = nblk;
                            end
                        end
                    end
                    A_GCNEED: begin
                        n_res.flag = (r_free[p] <= FREE_W'(1));
                    end
                    A_VICTIM: begin
                        n_state   = S_SCAN;
                        n_phase   = P_VICTIM;
                        n_sc_addr = lo;
                        n_sc_left = nblk;
                        n_got     = 1'b0;
                        n_min     = '0;
                        n_best    = '0;
                        n_bwp     = '0;
                    end
                    A_TRIM: begin
                        blk_we = 1'b1;
                        blk_wd = '0;
                    end
                    A_SETRSV: begin
                        n_rsv[p]        = r_req.block_index;
                        n_res.block_out = r_req.block_index;
                        n_res.found     = 1'b1;
                    end
                    default: begin
                        n_res = '0;
                    end
                endcase
            end
            S_SCAN: begin
                // one table read issued per cycle, checked in the next cycle
                if (r_sc_left != '0) begin
                    n_ck_vld  = 1'b1;
                    n_ck_idx  = r_sc_addr;
                    n_sc_addr = f_nxt(r_sc_addr, lo, hi);
                    n_sc_left = NUMB_W'(r_sc_left - 1'b1);
                end
                case (r_phase)
                    P_FIRST: begin
                        if (usable) begin
                            n_active[p] = r_ck_idx;
                            n_phase     = P_NEXT;
                            n_sc_addr   = f_nxt(r_ck_idx, lo, hi);
                            n_sc_left   = NUMB_W'(nblk - 1'b1);
                            n_ck_vld    = 1'b0;
                        end else if (r_sc_left == '0) begin
                            n_res            = '0;
                            n_res.error_code = E_NO_FREE;
                            n_state          = S_DONE;
                        end
                    end
                    P_NEXT: begin
                        if (usable) begin
                            n_res           = '0;
                            n_active[p]     = r_ck_idx;
                            n_act_vld[p]    = 1'b1;
                            n_res.block_out = r_ck_idx;
                            n_res.found     = 1'b1;
                            // a fresh block consumes a free block
                            if (ck_wp == '0) begin
                                if (r_free[p] != '0) begin
                                    n_free[p] = FREE_W'(r_free[p] - 1'b1);
                                end else begin
                                    n_res.error_code = E_NO_FREE;
                                end
                            end
                            n_state = S_DONE;
                        end else if (r_sc_left == '0) begin
                            n_res            = '0;
                            n_act_vld[p]     = 1'b0;
                            n_res.error_code = E_NO_FREE;
                            n_state          = S_DONE;
                        end
                    end
                    P_VICTIM: begin
                        n_got  = f_got;
                        n_min  = f_min;
                        n_bwp  = f_wp;
                        n_best = f_best;
                        if (r_sc_left == '0) begin
                            n_res = '0;
                            // an entirely valid best block is no victim
                            if (!f_got || {1'b0, f_min} >= ((CNT_W+1)'(f_wp) << GOFF_W)) begin
                                n_res.error_code = E_NO_VICTIM;
                            end else begin
                                n_res.block_out = f_best;
                                n_res.found     = 1'b1;
                            end
                            n_state = S_DONE;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_phase     <= P_FIRST;
            r_clr       <= '0;
            r_act_vld   <= '0;
            r_active[0] <= '0;
            r_active[1] <= '0;
            r_rsv[0]    <= MAP_LO;
            r_rsv[1]    <= DATA_LO;
            r_free[0]   <= MAP_FREE;
            r_free[1]   <= DATA_FREE;
            r_sc_left   <= '0;
            r_ck_vld    <= 1'b0;
            r_got       <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_clr     <= n_clr;
            r_act_vld <= n_act_vld;
            r_active  <= n_active;
            r_rsv     <= n_rsv;
            r_free    <= n_free;
            r_sc_left <= n_sc_left;
            r_ck_vld  <= n_ck_vld;
            r_got     <= n_got;
            if (r_state == S_DONE && out_free) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_req   <= in_d;
            r_maddr <= in_maddr;
            r_baddr <= in_baddr;
        end
        r_sc_addr <= n_sc_addr;
        r_ck_idx  <= n_ck_idx;
        r_best    <= n_best;
        r_min     <= n_min;
        r_bwp     <= n_bwp;
        r_res     <= n_res;
        if (r_state == S_DONE && out_free) begin
            r_out <= r_res;
        end
    end

endmodule
`default_nettype wire
